### hw/rtl/mag_pkg.sv
// mag_pkg: types, codes and constants shared by the management access gate.
// No dependencies; used by mag_core, mag_sec and management_access_gate_top.
package mag_pkg;

    // Input beat
    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  path;
        logic [15:0] source;
        logic        individual;
        logic [2:0]  new_mask;
        logic [31:0] now_ms;
    } mag_in_t;

    // Result beat
    typedef struct packed {
        logic        permitted;
        logic [2:0]  allowed_now;
        logic        unlock_active;
        logic [21:0] unlock_left_s;
        logic [31:0] refusals;
        logic [1:0]  last_refused_path;
        logic [15:0] last_refused_source;
        logic [2:0]  report;
        logic [31:0] summary_count;
    } mag_out_t;

    // Fields that pass through the seconds stages unchanged
    typedef struct packed {
        logic        permitted;
        logic [2:0]  allowed_now;
        logic        unlock_active;
        logic [31:0] refusals;
        logic [1:0]  last_refused_path;
        logic [15:0] last_refused_source;
        logic [2:0]  report;
        logic [31:0] summary_count;
    } mag_flags_t;

    // Decision stage -> seconds stages
    typedef struct packed {
        mag_flags_t  flags;
        logic [31:0] deadline;
        logic [31:0] now_ms;
    } mag_stage_t;

    typedef enum logic [2:0] {
        CMD_FRAME       = 3'd0,
        CMD_SET_MASK    = 3'd1,
        CMD_TOGGLE_TP   = 3'd2,
        CMD_TOGGLE_NET  = 3'd3,
        CMD_TOGGLE_ALL  = 3'd4,
        CMD_UNLOCK      = 3'd5,
        CMD_CANCEL      = 3'd6,
        CMD_TICK        = 3'd7
    } mag_cmd_t;

    localparam logic [2:0] RPT_NONE       = 3'd0;
    localparam logic [2:0] RPT_REFUSED    = 3'd1;
    localparam logic [2:0] RPT_CLIENT     = 3'd2;
    localparam logic [2:0] RPT_SUPPRESSED = 3'd3;
    localparam logic [2:0] RPT_EXPIRED    = 3'd4;
    localparam logic [2:0] RPT_SUMMARY    = 3'd5;
    localparam logic [2:0] RPT_CANCELLED  = 3'd6;

    localparam logic [1:0] CFG_DURATION = 2'd0;
    localparam logic [1:0] CFG_GRACE    = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    localparam logic [1:0] ARRIVE_ROUTING = 2'd0;
    localparam logic [1:0] ARRIVE_TP      = 2'd1;
    localparam logic [1:0] ARRIVE_TUNNEL  = 2'd2;
    localparam logic [1:0] ARRIVE_UNKNOWN = 2'd3;

    localparam logic [2:0] OPEN_TP      = 3'd1;
    localparam logic [2:0] OPEN_TUNNEL  = 3'd2;
    localparam logic [2:0] OPEN_ROUTING = 3'd4;
    localparam logic [2:0] OPEN_NET     = 3'd6;
    localparam logic [2:0] OPEN_ALL     = 3'd7;

    localparam logic [30:0] DURATION_RESET = 31'd900000;
    localparam logic [30:0] GRACE_RESET    = 31'd60000;
    localparam logic [30:0] INTERVAL_RESET = 31'd10000;

    // Seconds rounded up: (d + 999) / 1000 = ((x >> 3) * RECIP_125) >> 36
    localparam logic [31:0] ROUND_UP_MS = 32'd999;
    localparam logic [29:0] RECIP_125   = 30'h20C4_9BA6;
    localparam int          RECIP_SHIFT = 36;

endpackage

### hw/rtl/management_access_gate_top.sv
// management_access_gate_top: top level of the management access gate.
// Depends on mag_pkg, mag_core and mag_sec.
//
// Usage
//   s_ channel: one beat per frame check or command (set/toggle mask,
//   unlock, cancel, tick), carrying the time in ms. m_ channel: one result
//   beat per input beat, in order: verdict, mask, unlock state and
//   remaining seconds, refusal counters and a report code.
//   cfg_we/cfg_index/cfg_wdata write the unlock duration, grace time and
//   report interval; write only while the gate is idle.
// Pipeline: a result beat passes the decision, rounding and result
//   registers in that order before it is on m_.
// Throughput: one beat per cycle while no result is held on m_. Gate state
//   is updated at the accepting edge, so the next beat sees it straight away.
// Stall: the three stages advance together. While a result waits on
//   m_ready low, s_ready is low; otherwise beats flow every cycle.
// Reset: aresetn low (synchronous) empties the pipeline, opens every path,
//   stops any unlock, clears the counters and restores register defaults.
module management_access_gate_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mag_pkg::mag_in_t     s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mag_pkg::mag_out_t    m_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [30:0]          cfg_wdata
);

    logic en;
    logic accept;
    logic a_valid_reg, b_valid_reg, m_valid_reg;

    mag_pkg::mag_stage_t stage;

    // whole pipeline moves unless a result is held by the receiver
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign accept  = s_valid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    mag_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .en        (en),
        .in_item   (s_data),
        .stage_q   (stage)
    );

    mag_sec u_sec (
        .aclk     (aclk),
        .en       (en),
        .stage_d  (stage),
        .result_q (m_data)
    );

    assign m_valid = m_valid_reg;

    // remaining seconds only while an unlock runs
    a_left_needs_unlock: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.unlock_left_s != 22'd0) |-> m_data.unlock_active)
        else $error("unlock seconds without active unlock");

    // a let-in frame never raises a report
    a_permit_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.permitted) |-> (m_data.report == mag_pkg::RPT_NONE))
        else $error("report on permitted frame");

    // summary count only goes out with a summary report
    a_summary_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.summary_count != 32'd0)
        |-> (m_data.report == mag_pkg::RPT_SUMMARY))
        else $error("summary count without summary report");

    // input only held off while a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

    // a beat accepted with the pipeline moving reaches stage one
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> a_valid_reg)
        else $error("accepted beat lost");

endmodule

### hw/rtl/mag_core.sv
// mag_core: configuration registers, gate state and per-beat decision.
// Depends on mag_pkg. Registers the decision for the seconds stages.
module mag_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [30:0]           cfg_wdata,
    input  logic                  accept,
    input  logic                  en,
    input  mag_pkg::mag_in_t      in_item,
    output mag_pkg::mag_stage_t   stage_q
);

    logic [30:0] duration_reg, grace_reg, interval_reg;

    logic [2:0]  allowed_reg, allowed_next;
    logic [2:0]  remembered_reg, remembered_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] refused_reg, refused_next;
    logic [1:0]  lpath_reg, lpath_next;
    logic [15:0] lsrc_reg, lsrc_next;
    logic [31:0] rtime_reg, rtime_next;
    logic [31:0] supp_reg, supp_next;

    mag_pkg::mag_stage_t stage_reg, stage_next;

    logic [2:0]  path_bit;
    logic        path_open;
    logic [31:0] at_least, ext_diff, since_report, since_deadline;
    logic [31:0] interval_ext;
    logic        permitted;
    logic [2:0]  report;
    logic [31:0] summary;
    logic [2:0]  net_rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg <= mag_pkg::DURATION_RESET;
            grace_reg    <= mag_pkg::GRACE_RESET;
            interval_reg <= mag_pkg::INTERVAL_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                mag_pkg::CFG_DURATION: duration_reg <= cfg_wdata;
                mag_pkg::CFG_GRACE:    grace_reg    <= cfg_wdata;
                mag_pkg::CFG_INTERVAL: interval_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (in_item.path)
            mag_pkg::ARRIVE_ROUTING: path_bit = mag_pkg::OPEN_ROUTING;
            mag_pkg::ARRIVE_TP:      path_bit = mag_pkg::OPEN_TP;
            mag_pkg::ARRIVE_TUNNEL:  path_bit = mag_pkg::OPEN_TUNNEL;
            default:                 path_bit = 3'd0;
        endcase
    end

    assign path_open      = (in_item.path == mag_pkg::ARRIVE_UNKNOWN)
                            || ((allowed_reg & path_bit) != 3'd0);
    assign at_least       = in_item.now_ms + {1'b0, grace_reg};
    assign ext_diff       = at_least - deadline_reg;
    assign since_report   = in_item.now_ms - rtime_reg;
    assign since_deadline = in_item.now_ms - deadline_reg;
    assign interval_ext   = {1'b0, interval_reg};
    assign net_rem        = remembered_reg & mag_pkg::OPEN_NET;

    always_comb begin
        allowed_next    = allowed_reg;
        remembered_next = remembered_reg;
        deadline_next   = deadline_reg;
        refused_next    = refused_reg;
        lpath_next      = lpath_reg;
        lsrc_next       = lsrc_reg;
        rtime_next      = rtime_reg;
        supp_next       = supp_reg;
        permitted       = 1'b0;
        report          = mag_pkg::RPT_NONE;
        summary         = 32'd0;

        unique case (mag_pkg::mag_cmd_t'(in_item.command))
            mag_pkg::CMD_FRAME: begin
                if (path_open) begin
                    permitted = 1'b1;
                end else if (deadline_reg != 32'd0) begin
                    // unlock running: individual frame keeps at least the grace time
                    if (in_item.individual && ext_diff != 32'd0 && !ext_diff[31]) begin
                        deadline_next = at_least | 32'd1;
                    end
                    permitted = 1'b1;
                end else if (in_item.individual) begin
                    refused_next = refused_reg + 32'd1;
                    lpath_next   = in_item.path;
                    lsrc_next    = in_item.source;
                    if (rtime_reg != 32'd0 && since_report < interval_ext) begin
                        supp_next = supp_reg + 32'd1;
                        report    = mag_pkg::RPT_SUPPRESSED;
                    end else begin
                        report     = (in_item.source != 16'd0) ? mag_pkg::RPT_REFUSED
                                                               : mag_pkg::RPT_CLIENT;
                        rtime_next = in_item.now_ms;
                    end
                end
            end
            mag_pkg::CMD_SET_MASK: begin
                allowed_next = in_item.new_mask;
                if (in_item.new_mask != 3'd0) begin
                    remembered_next = in_item.new_mask;
                end
            end
            mag_pkg::CMD_TOGGLE_TP: begin
                allowed_next = allowed_reg ^ mag_pkg::OPEN_TP;
            end
            mag_pkg::CMD_TOGGLE_NET: begin
                if ((allowed_reg & mag_pkg::OPEN_NET) != 3'd0) begin
                    remembered_next = allowed_reg;
                    allowed_next    = allowed_reg & ~mag_pkg::OPEN_NET;
                end else begin
                    allowed_next = allowed_reg
                                   | ((net_rem != 3'd0) ? net_rem : mag_pkg::OPEN_NET);
                end
            end
            mag_pkg::CMD_TOGGLE_ALL: begin
                if (allowed_reg != 3'd0) begin
                    remembered_next = allowed_reg;
                    allowed_next    = 3'd0;
                end else begin
                    allowed_next = (remembered_reg != 3'd0) ? remembered_reg
                                                            : mag_pkg::OPEN_ALL;
                end
            end
            mag_pkg::CMD_UNLOCK: begin
                deadline_next = (in_item.now_ms + {1'b0, duration_reg}) | 32'd1;
            end
            mag_pkg::CMD_CANCEL: begin
                if (deadline_reg != 32'd0) begin
                    deadline_next = 32'd0;
                    report        = mag_pkg::RPT_CANCELLED;
                end
            end
            mag_pkg::CMD_TICK: begin
                if (deadline_reg != 32'd0 && !since_deadline[31]) begin
                    deadline_next = 32'd0;
                    report        = mag_pkg::RPT_EXPIRED;
                end
                if (supp_reg != 32'd0 && since_report >= interval_ext) begin
                    summary    = supp_reg;
                    report     = mag_pkg::RPT_SUMMARY;
                    supp_next  = 32'd0;
                    rtime_next = in_item.now_ms;
                end
            end
            default: ;
        endcase

        stage_next.flags.permitted           = permitted;
        stage_next.flags.allowed_now         = allowed_next;
        stage_next.flags.unlock_active       = (deadline_next != 32'd0);
        stage_next.flags.refusals            = refused_next;
        stage_next.flags.last_refused_path   = lpath_next;
        stage_next.flags.last_refused_source = lsrc_next;
        stage_next.flags.report              = report;
        stage_next.flags.summary_count       = summary;
        stage_next.deadline                  = deadline_next;
        stage_next.now_ms                    = in_item.now_ms;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allowed_reg    <= mag_pkg::OPEN_ALL;
            remembered_reg <= mag_pkg::OPEN_ALL;
            deadline_reg   <= 32'd0;
            refused_reg    <= 32'd0;
            lpath_reg      <= 2'd0;
            lsrc_reg       <= 16'd0;
            rtime_reg      <= 32'd0;
            supp_reg       <= 32'd0;
        end else if (accept) begin
            allowed_reg    <= allowed_next;
            remembered_reg <= remembered_next;
            deadline_reg   <= deadline_next;
            refused_reg    <= refused_next;
            lpath_reg      <= lpath_next;
            lsrc_reg       <= lsrc_next;
            rtime_reg      <= rtime_next;
            supp_reg       <= supp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_q = stage_reg;

endmodule

### hw/rtl/mag_sec.sv
// mag_sec: remaining-unlock seconds, rounded up, in two registered stages.
// Depends on mag_pkg. Difference and rounding first, then reciprocal multiply.
module mag_sec (
    input  logic                  aclk,
    input  logic                  en,
    input  mag_pkg::mag_stage_t   stage_d,
    output mag_pkg::mag_out_t     result_q
);

    logic [31:0] diff;
    logic        left_ok;

    mag_pkg::mag_flags_t flags_reg;
    logic [31:0]         x_reg;
    logic                ok_reg;

    logic [58:0]         prod;
    logic [21:0]         left_s;
    mag_pkg::mag_out_t   result_reg, result_next;

    // ms still to run; only counts when the deadline lies strictly ahead
    assign diff    = stage_d.deadline - stage_d.now_ms;
    assign left_ok = (stage_d.deadline != 32'd0) && (diff != 32'd0) && !diff[31];

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg <= stage_d.flags;
            x_reg     <= diff + mag_pkg::ROUND_UP_MS;
            ok_reg    <= left_ok;
        end
    end

    assign prod   = x_reg[31:3] * mag_pkg::RECIP_125;
    assign left_s = ok_reg ? prod[mag_pkg::RECIP_SHIFT +: 22] : 22'd0;

    always_comb begin
        result_next.permitted           = flags_reg.permitted;
        result_next.allowed_now         = flags_reg.allowed_now;
        result_next.unlock_active       = flags_reg.unlock_active;
        result_next.unlock_left_s       = left_s;
        result_next.refusals            = flags_reg.refusals;
        result_next.last_refused_path   = flags_reg.last_refused_path;
        result_next.last_refused_source = flags_reg.last_refused_source;
        result_next.report              = flags_reg.report;
        result_next.summary_count       = flags_reg.summary_count;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result_q = result_reg;

endmodule
